>>> rtl/port_power_sequencer_core_assert.svh
// assertion macros shared by the port power sequencer rtl
`ifndef PORT_POWER_SEQUENCER_CORE_ASSERT_SVH
`define PORT_POWER_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pps_pkg.sv
// types and constants of the port power sequencer
`default_nettype none

package pps_pkg;

	localparam int NumPorts = 4;

	// command words and header byte
	localparam logic [31:0] CMD_ALL_OFF = 32'hA201_01A0;
	localparam logic [31:0] CMD_ALL_ON  = 32'hA100_01A0;
	localparam logic [31:0] CMD_STATUS  = 32'hFDFF_FFFF;
	localparam logic [7:0]  HDR_DIRECT  = 8'hF0;

	// item kinds
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_CMD  = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DEFAULT_ON = 2'd0,
		REG_GROUP      = 2'd1,
		REG_POLARITY   = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_index_t;

	localparam logic [3:0] DEFAULT_ON_RESET = 4'h7;
	localparam logic [3:0] GROUP_RESET      = 4'hF;
	localparam logic [3:0] POLARITY_RESET   = 4'h8;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_OFF   = 4'b0010,
		MODE_ON    = 4'b0100,
		MODE_START = 4'b1000
	} seq_mode_t;

endpackage

`default_nettype wire

>>> rtl/pps_item_if.sv
// input item channel: tick or command word
`default_nettype none

interface pps_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic        button;
	logic [31:0] cmd_word;

	modport source (output valid, output func, output button, output cmd_word, input ready);
	modport sink (input valid, input func, input button, input cmd_word, output ready);
endinterface

`default_nettype wire

>>> rtl/pps_result_if.sv
// result channel: pin levels and readback reply
`default_nettype none

interface pps_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  port_pins;
	logic        checksum_ok;
	logic        reply_valid;
	logic [3:0]  reply_pins;
	logic [31:0] reply_settings;

	modport source (output valid, output port_pins, output checksum_ok, output reply_valid,
		output reply_pins, output reply_settings, input ready);
	modport sink (input valid, input port_pins, input checksum_ok, input reply_valid,
		input reply_pins, input reply_settings, output ready);
endinterface

`default_nettype wire

>>> rtl/port_power_sequencer_core.sv
// port power sequencer: four enable pins driven by ticks and command words
//
// channels: item (sink) carries a tick with a button sample or a 32-bit
// command word; result (source) returns one result per item with the pin
// levels after it, the checksum flag and the status readback reply.
// configuration: write port cfg_we/cfg_index/cfg_data; the user must write it
// only while idle, the block itself does not enforce this. an accepted item
// passes through the input register, then through the sequencer logic into the
// result register. throughput: one item per cycle while results are taken; the
// input register advances whenever the result register is empty or being taken,
// so a stalled receiver only backs up the two stages and then drops item.ready.
// reset: pins low, sequencer set to walk the default levels out one port per
// tick, group marked on, cooldown zero, registers at their reset values.
// a button press is taken only when the cooldown is zero and reloads it to
// COOLDOWN_TICKS - 1; each tick drives one port of the running sequence.
`default_nettype none

module port_power_sequencer_core #(
	parameter int COOLDOWN_TICKS = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [3:0] cfg_data,
	pps_item_if.sink        item,
	pps_result_if.source    result
);

`include "port_power_sequencer_core_assert.svh"

	localparam int CdW = $clog2(COOLDOWN_TICKS + 1);

	// configuration
	logic [3:0] default_on_q, group_q, polarity_q;

	// sequencer state
	logic [3:0]          pins_q;
	pps_pkg::seq_mode_t  mode_q;
	logic [1:0]          seq_port_q;
	logic                ports_on_q;
	logic [CdW-1:0]      cooldown_q;

	// input stage
	logic        valid_s1;
	logic        func_s1;
	logic        button_s1;
	logic [31:0] cmd_word_s1;

	// result stage
	logic        valid_s2;
	logic [3:0]  port_pins_s2;
	logic        checksum_ok_s2;
	logic        reply_valid_s2;
	logic [3:0]  reply_pins_s2;
	logic [31:0] reply_settings_s2;

	logic advance;

	// next-state logic
	logic [3:0]         pins_n;
	pps_pkg::seq_mode_t mode_n;
	logic [1:0]         seq_port_n;
	logic               ports_on_n;
	logic [CdW-1:0]     cooldown_n;
	logic               ck_ok;
	logic               rv;
	logic [31:0]        rset;
	logic [7:0]         b0, b1, b2, b3;
	logic               press;
	logic [1:0]         direct_idx;

	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_on_q <= pps_pkg::DEFAULT_ON_RESET;
			group_q      <= pps_pkg::GROUP_RESET;
			polarity_q   <= pps_pkg::POLARITY_RESET;
		end else if (cfg_we) begin
			unique case (pps_pkg::reg_index_t'(cfg_index))
				pps_pkg::REG_DEFAULT_ON: default_on_q <= cfg_data;
				pps_pkg::REG_GROUP:      group_q      <= cfg_data;
				pps_pkg::REG_POLARITY:   polarity_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		b0 = cmd_word_s1[7:0];
		b1 = cmd_word_s1[15:8];
		b2 = cmd_word_s1[23:16];
		b3 = cmd_word_s1[31:24];
		pins_n     = pins_q;
		mode_n     = mode_q;
		seq_port_n = seq_port_q;
		ports_on_n = ports_on_q;
		cooldown_n = cooldown_q;
		ck_ok      = 1'b0;
		rv         = 1'b0;
		rset       = '0;
		press      = 1'b0;
		direct_idx = 2'(b1 - 8'd1);

		if (func_s1 == pps_pkg::FUNC_TICK) begin
			press = button_s1 && (cooldown_q == '0);
			if (press) begin
				mode_n     = ports_on_q ? pps_pkg::MODE_OFF : pps_pkg::MODE_ON;
				seq_port_n = 2'd0;
				ports_on_n = !ports_on_q;
			end
			// one port of the running sequence per tick
			unique case (mode_n)
				pps_pkg::MODE_IDLE: ;
				pps_pkg::MODE_START: pins_n[seq_port_n] = default_on_q[seq_port_n];
				pps_pkg::MODE_OFF: begin
					if (group_q[seq_port_n])
						pins_n[seq_port_n] = polarity_q[seq_port_n];
				end
				pps_pkg::MODE_ON: begin
					if (group_q[seq_port_n])
						pins_n[seq_port_n] = !polarity_q[seq_port_n];
				end
				default: ;
			endcase
			if (mode_n != pps_pkg::MODE_IDLE) begin
				if (seq_port_n == 2'd3) begin
					mode_n     = pps_pkg::MODE_IDLE;
					seq_port_n = 2'd0;
				end else begin
					seq_port_n = seq_port_n + 2'd1;
				end
			end
			if (press)
				cooldown_n = CdW'(COOLDOWN_TICKS - 1);
			else if (cooldown_q != '0)
				cooldown_n = cooldown_q - 1'b1;
		end else begin
			ck_ok = (8'(b0 + b1 + b2) == b3);
			if (ck_ok) begin
				if (cmd_word_s1 == pps_pkg::CMD_ALL_OFF) begin
					mode_n     = pps_pkg::MODE_OFF;
					seq_port_n = 2'd0;
					ports_on_n = 1'b0;
				end else if (cmd_word_s1 == pps_pkg::CMD_ALL_ON) begin
					mode_n     = pps_pkg::MODE_ON;
					seq_port_n = 2'd0;
					ports_on_n = 1'b1;
				end else if (cmd_word_s1 == pps_pkg::CMD_STATUS) begin
					rv = 1'b1;
					for (int k = 0; k < pps_pkg::NumPorts; k++)
						rset[8*k +: 8] = {5'd0, polarity_q[k], group_q[k], default_on_q[k]};
				end else if (b0 == pps_pkg::HDR_DIRECT && b1 >= 8'd1 && b1 <= 8'd4) begin
					pins_n[direct_idx] = b2[0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			pins_q     <= '0;
			mode_q     <= pps_pkg::MODE_START;
			seq_port_q <= 2'd0;
			ports_on_q <= 1'b1;
			cooldown_q <= '0;
		end else begin
			if (item.ready)
				valid_s1 <= item.valid;
			if (advance) begin
				valid_s2   <= 1'b1;
				pins_q     <= pins_n;
				mode_q     <= mode_n;
				seq_port_q <= seq_port_n;
				ports_on_q <= ports_on_n;
				cooldown_q <= cooldown_n;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_s1     <= item.func;
			button_s1   <= item.button;
			cmd_word_s1 <= item.cmd_word;
		end
		if (advance) begin
			port_pins_s2      <= pins_n;
			checksum_ok_s2    <= ck_ok;
			reply_valid_s2    <= rv;
			reply_pins_s2     <= rv ? pins_q : 4'd0;
			reply_settings_s2 <= rset;
		end
	end

	assign result.valid          = valid_s2;
	assign result.port_pins      = port_pins_s2;
	assign result.checksum_ok    = checksum_ok_s2;
	assign result.reply_valid    = reply_valid_s2;
	assign result.reply_pins     = reply_pins_s2;
	assign result.reply_settings = reply_settings_s2;

	`PPS_ASSERT_IMPL(a_reply_needs_checksum, clk, arst_n,
		valid_s2 && reply_valid_s2, checksum_ok_s2, "readback reply without good checksum")
	`PPS_ASSERT_IMPL(a_reply_pins_match, clk, arst_n,
		valid_s2 && reply_valid_s2, reply_pins_s2 == port_pins_s2,
		"readback changed the pins")
	`PPS_ASSERT_IMPL(a_idle_port_zero, clk, arst_n,
		mode_q == pps_pkg::MODE_IDLE, seq_port_q == 2'd0, "idle sequencer off first port")
	`PPS_ASSERT_NEXT(a_cooldown_counts, clk, arst_n,
		advance && func_s1 == pps_pkg::FUNC_TICK && cooldown_q != '0,
		cooldown_q == $past(cooldown_q) - 1'b1, "cooldown did not count down")

endmodule

`default_nettype wire
